FILE: hdl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the address-resolution cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int unsigned DEF_ENTRIES = 16;
    localparam int unsigned NET_W       = 16;
    localparam int unsigned HW_W        = 48;
    localparam int unsigned AGE_W       = 32;

    localparam logic OP_LEARN   = 1'b0;
    localparam logic OP_RESOLVE = 1'b1;

    localparam logic [AGE_W-1:0] FILL_AGE        = 32'd1;
    localparam logic [AGE_W-1:0] USE_CLOCK_RESET = 32'd1;

    typedef struct packed {
        logic [AGE_W-1:0] age;
        logic [HW_W-1:0]  hw;
        logic [NET_W-1:0] net;
    } entry_t;

    typedef struct packed {
        logic            dropped;
        logic            need_request;
        logic            use_broadcast;
        logic            send_reply;
        logic [HW_W-1:0] hw_addr_out;
        logic            hit;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WB,
        ST_RESP
    } state_t;

endpackage

FILE: hdl/arpc_mem.sv
// ----------------------------------------------------------------------------
// arpc_mem
// Entry memory with one write port and one registered read port. Each entry
// has a valid bit that reset clears, and an entry not yet written reads as
// all zero.
// ----------------------------------------------------------------------------
module arpc_mem #(
    parameter int unsigned ENTRIES = arpc_pkg::DEF_ENTRIES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [$clog2(ENTRIES)-1:0] rd_addr,
    output arpc_pkg::entry_t           rd_data,
    input  logic                       wr_en,
    input  logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  arpc_pkg::entry_t           wr_data
);
    import arpc_pkg::*;

    entry_t             mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    entry_t             rd_data_reg;
    logic               rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: hdl/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer of the cache: takes one beat, walks the entries through the
// memory read port one per cycle (a dropped or broadcast beat skips this), writes
// the chosen entry back when the beat updates one and forms the result.
// ----------------------------------------------------------------------------
module arpc_ctrl #(
    parameter int unsigned ENTRIES = arpc_pkg::DEF_ENTRIES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [arpc_pkg::NET_W-1:0] cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_op,
    input  logic [arpc_pkg::NET_W-1:0] in_peer,
    input  logic [arpc_pkg::HW_W-1:0]  in_hw,
    input  logic [arpc_pkg::NET_W-1:0] in_tgt,
    input  logic                       in_req,
    output logic                       rd_en,
    output logic [$clog2(ENTRIES)-1:0] rd_addr,
    input  arpc_pkg::entry_t           rd_data,
    output logic                       wr_en,
    output logic [$clog2(ENTRIES)-1:0] wr_addr,
    output arpc_pkg::entry_t           wr_data,
    output logic                       res_valid,
    input  logic                       res_ready,
    output arpc_pkg::res_t             res
);
    import arpc_pkg::*;

    localparam int unsigned IDXW = $clog2(ENTRIES);
    localparam int unsigned CNTW = $clog2(ENTRIES + 1);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);
    localparam logic [CNTW-1:0] CNT_END  = CNTW'(ENTRIES);

    state_t           state_reg, state_next;
    logic [NET_W-1:0] my_addr_reg;
    logic             op_reg;
    logic [NET_W-1:0] peer_reg;
    logic [HW_W-1:0]  hw_reg;
    logic [NET_W-1:0] tgt_reg;
    logic             req_reg;
    logic [CNTW-1:0]  issue_cnt_reg, issue_cnt_next;
    logic [IDXW-1:0]  proc_idx_reg;
    logic             rd_pend_reg;
    logic [IDXW-1:0]  victim_reg, victim_next;
    logic [AGE_W-1:0] vage_reg, vage_next;
    logic             found_reg, found_next;
    logic [IDXW-1:0]  hit_idx_reg, hit_idx_next;
    entry_t           hit_entry_reg, hit_entry_next;
    logic [AGE_W-1:0] use_clock_reg, use_clock_next;
    res_t             res_reg, res_next;

    logic accept;
    logic early_done;
    logic stop;
    logic for_us;
    logic issue;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign early_done = (in_op == OP_LEARN) ? (in_peer == '0 || in_tgt == '0)
                                            : (in_peer == '0);
    assign for_us     = (tgt_reg == my_addr_reg);
    assign issue      = (state_reg == ST_SCAN) && (issue_cnt_reg != CNT_END);

    assign rd_en   = issue;
    assign rd_addr = issue_cnt_reg[IDXW-1:0];

    always_comb
    begin
        stop           = 1'b0;
        found_next     = found_reg;
        hit_idx_next   = hit_idx_reg;
        hit_entry_next = hit_entry_reg;
        victim_next    = victim_reg;
        vage_next      = vage_reg;
        issue_cnt_next = issue ? issue_cnt_reg + CNTW'(1) : issue_cnt_reg;
        if (state_reg == ST_IDLE)
        begin
            found_next     = 1'b0;
            victim_next    = '0;
            issue_cnt_next = '0;
        end
        else if (state_reg == ST_SCAN && rd_pend_reg)
        begin
            if (op_reg == OP_LEARN)
            begin
                if (rd_data.net == peer_reg)
                begin
                    stop           = 1'b1;
                    found_next     = 1'b1;
                    hit_idx_next   = proc_idx_reg;
                    hit_entry_next = rd_data;
                end
                else if (proc_idx_reg == '0)
                begin
                    vage_next = rd_data.age;
                end
                else if (rd_data.age < vage_reg)
                begin
                    victim_next = proc_idx_reg;
                    vage_next   = rd_data.age;
                    if (rd_data.net == '0)
                    begin
                        stop = 1'b1;
                    end
                end
            end
            else
            begin
                if (rd_data.net == '0)
                begin
                    stop = 1'b1;
                end
                else if (rd_data.net == peer_reg)
                begin
                    stop           = 1'b1;
                    found_next     = 1'b1;
                    hit_idx_next   = proc_idx_reg;
                    hit_entry_next = rd_data;
                end
            end
            if (proc_idx_reg == LAST_IDX)
            begin
                stop = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = early_done ? ST_RESP : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stop)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wr_en          = 1'b0;
        wr_addr        = hit_idx_reg;
        wr_data        = hit_entry_reg;
        use_clock_next = use_clock_reg;
        res_next       = res_reg;
        res_valid      = (state_reg == ST_RESP);
        case (state_reg)
            ST_IDLE:
            begin
                res_next               = '0;
                res_next.dropped       = (in_op == OP_LEARN);
                res_next.use_broadcast = (in_op == OP_RESOLVE);
            end
            ST_WB:
            begin
                res_next = '0;
                if (op_reg == OP_LEARN)
                begin
                    res_next.hit        = found_reg;
                    res_next.send_reply = for_us && req_reg;
                    if (found_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_data.hw = hw_reg;
                    end
                    else if (for_us)
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = victim_reg;
                        wr_data.age = FILL_AGE;
                        wr_data.hw  = hw_reg;
                        wr_data.net = peer_reg;
                    end
                end
                else
                begin
                    if (found_reg)
                    begin
                        use_clock_next       = use_clock_reg + AGE_W'(1);
                        wr_en                = 1'b1;
                        wr_data.age          = use_clock_next;
                        res_next.hit         = 1'b1;
                        res_next.hw_addr_out = hit_entry_reg.hw;
                    end
                    else
                    begin
                        res_next.need_request = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            my_addr_reg   <= '0;
            use_clock_reg <= USE_CLOCK_RESET;
            rd_pend_reg   <= 1'b0;
            issue_cnt_reg <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            use_clock_reg <= use_clock_next;
            rd_pend_reg   <= issue;
            issue_cnt_reg <= issue_cnt_next;
            found_reg     <= found_next;
            if (cfg_we)
            begin
                my_addr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= in_op;
            peer_reg <= in_peer;
            hw_reg   <= in_hw;
            tgt_reg  <= in_tgt;
            req_reg  <= in_req;
        end
        proc_idx_reg  <= rd_addr;
        victim_reg    <= victim_next;
        vage_reg      <= vage_next;
        hit_idx_reg   <= hit_idx_next;
        hit_entry_reg <= hit_entry_next;
        res_reg       <= res_next;
    end

`ifndef NO_ASSERTIONS
    a_hit_excl : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.hit && res.need_request))
        else $error("hit and need_request both set");

    a_drop_clean : assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.dropped) |->
            (!res.hit && !res.send_reply && res.hw_addr_out == '0))
        else $error("dropped result carries other fields");

    a_clock_step : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB && op_reg == OP_RESOLVE && found_reg) |=>
            (use_clock_reg == $past(use_clock_reg) + AGE_W'(1)))
        else $error("use clock not advanced on resolve hit");

    a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("new beat taken before the previous one finished");

    a_no_write_scan : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !wr_en)
        else $error("entry written during a scan");
`endif

endmodule

FILE: hdl/arp_cache_lru_top.sv
// A beat is taken only while idle: a dropped or broadcast beat goes straight to its
// result; any other beat first scans up to ENTRIES entries, as the memory read port
// reads one entry a cycle, then passes the write-back state. No new beat is taken
// until the result of the previous one has moved into the output register.
// A finished result waits in the output register while the next beat is taken.
// Reset (rst_n, asynchronous, active low) empties every entry and sets the use clock to one.
// ----------------------------------------------------------------------------
// arp_cache_lru_top
// Address-resolution cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
module arp_cache_lru_top #(
    parameter int unsigned ENTRIES = arpc_pkg::DEF_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // peer_net_addr, peer_hw_addr, target_net_addr
    input  logic [79:0] s_axis_tdata,
    // operation, is_request, zero fill
    input  logic [7:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // hw_addr_out
    output logic [47:0] m_axis_tdata,
    // hit, send_reply, use_broadcast, need_request, dropped, zero fill
    output logic [7:0]  m_axis_tuser
);
    import arpc_pkg::*;

    localparam int unsigned IDXW = $clog2(ENTRIES);

    logic            rd_en;
    logic [IDXW-1:0] rd_addr;
    entry_t          rd_data;
    logic            wr_en;
    logic [IDXW-1:0] wr_addr;
    entry_t          wr_data;
    logic            res_valid;
    logic            res_ready;
    res_t            res;
    logic            out_valid_reg;
    res_t            out_res_reg;

    arpc_mem #(
        .ENTRIES (ENTRIES)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    arpc_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser[0]),
        .in_peer   (s_axis_tdata[15:0]),
        .in_hw     (s_axis_tdata[63:16]),
        .in_tgt    (s_axis_tdata[79:64]),
        .in_req    (s_axis_tuser[1]),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg.hw_addr_out;
    assign m_axis_tuser  = {3'b000, out_res_reg.dropped, out_res_reg.need_request,
                            out_res_reg.use_broadcast, out_res_reg.send_reply,
                            out_res_reg.hit};

endmodule

FILE: tb/tb_arp_cache_lru_top.sv
// ----------------------------------------------------------------------------
// tb_arp_cache_lru_top
// Self-checking testbench for the address-resolution cache with LRU replacement.
// A tracker class keeps its own copy of the cache, predicts the result of every
// beat taken on the input stream and compares each result beat with the oldest
// prediction. Directed beats cover drops, broadcast, misses, fills, refreshes
// and replies; random phases then work a small address pool under several
// settings of our own address, with bursty input and patterned or random output stalls.
// ----------------------------------------------------------------------------
module tb_arp_cache_lru_top;

    timeunit 1ns;
    timeprecision 1ps;

    import arpc_pkg::*;

    localparam int unsigned TB_ENTRIES  = DEF_ENTRIES;
    localparam int          IDLE_LIMIT  = 4000;
    localparam int          SETTLE_CYC  = 30;
    localparam int          PHASE_BEATS = 140;
    localparam int          POOL_SIZE   = 24;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [15:0] cfg_wdata     = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata  = '0;
    logic [7:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [7:0]  m_axis_tuser;

    class arp_table_tracker;
        logic [NET_W-1:0] slot_net[TB_ENTRIES];
        logic [HW_W-1:0]  slot_hw[TB_ENTRIES];
        logic [AGE_W-1:0] slot_age[TB_ENTRIES];
        logic [AGE_W-1:0] use_clk;
        logic [NET_W-1:0] own_addr;
        res_t             pending_answers[$];
        int errors;
        int beats_in;
        int fills;
        int evictions;
        int learn_hits;
        int replies;
        int drops;
        int resolve_hits;
        int requests;
        int broadcasts;

        function new();
            for (int i = 0; i < TB_ENTRIES; i++)
            begin
                slot_net[i] = '0;
                slot_hw[i]  = '0;
                slot_age[i] = '0;
            end
            use_clk  = USE_CLOCK_RESET;
            own_addr = '0;
        endfunction

        task note_mismatch(string what, logic [47:0] got, logic [47:0] want);
            errors++;
            $display("[%0t] mismatch: %s, got %h, expected %h", $time, what, got, want);
        endtask

        function void take_request(logic op, logic [NET_W-1:0] peer, logic [HW_W-1:0] hw,
                                   logic [NET_W-1:0] tgt, logic req);
            res_t ans;
            int   victim;
            int   hit_idx;
            bit   done;
            ans     = '0;
            victim  = 0;
            hit_idx = -1;
            done    = 1'b0;
            beats_in++;
            if (op == OP_LEARN)
            begin
                if (peer == '0 || tgt == '0)
                begin
                    ans.dropped = 1'b1;
                    drops++;
                end
                else
                begin
                    for (int i = 0; i < TB_ENTRIES && !done; i++)
                    begin
                        if (slot_net[i] == peer)
                        begin
                            hit_idx = i;
                            done    = 1'b1;
                        end
                        else if (slot_age[i] < slot_age[victim])
                        begin
                            victim = i;
                            if (slot_net[i] == '0)
                                done = 1'b1;
                        end
                    end
                    if (hit_idx >= 0)
                    begin
                        slot_hw[hit_idx] = hw;
                        ans.hit          = 1'b1;
                        learn_hits++;
                    end
                    if (tgt == own_addr)
                    begin
                        if (hit_idx < 0)
                        begin
                            if (slot_net[victim] != '0)
                                evictions++;
                            slot_hw[victim]  = hw;
                            slot_net[victim] = peer;
                            slot_age[victim] = FILL_AGE;
                            fills++;
                        end
                        ans.send_reply = req;
                        if (req)
                            replies++;
                    end
                end
            end
            else if (peer == '0)
            begin
                ans.use_broadcast = 1'b1;
                broadcasts++;
            end
            else
            begin
                for (int i = 0; i < TB_ENTRIES && !done && slot_net[i] != '0; i++)
                begin
                    if (slot_net[i] == peer)
                    begin
                        use_clk         = use_clk + 1'b1;
                        slot_age[i]     = use_clk;
                        ans.hit         = 1'b1;
                        ans.hw_addr_out = slot_hw[i];
                        done            = 1'b1;
                        resolve_hits++;
                    end
                end
                if (!done)
                begin
                    ans.need_request = 1'b1;
                    requests++;
                end
            end
            pending_answers.push_back(ans);
        endfunction

        task match_answer(logic [47:0] data, logic [7:0] user);
            res_t want;
            if (pending_answers.size() == 0)
            begin
                note_mismatch("result beat with nothing pending", data, '0);
                return;
            end
            want = pending_answers.pop_front();
            if (user[0] !== want.hit)
                note_mismatch("hit", 48'(user[0]), 48'(want.hit));
            if (data !== want.hw_addr_out)
                note_mismatch("hw_addr_out", data, want.hw_addr_out);
            if (user[1] !== want.send_reply)
                note_mismatch("send_reply", 48'(user[1]), 48'(want.send_reply));
            if (user[2] !== want.use_broadcast)
                note_mismatch("use_broadcast", 48'(user[2]), 48'(want.use_broadcast));
            if (user[3] !== want.need_request)
                note_mismatch("need_request", 48'(user[3]), 48'(want.need_request));
            if (user[4] !== want.dropped)
                note_mismatch("dropped", 48'(user[4]), 48'(want.dropped));
            if (user[7:5] !== 3'b000)
                note_mismatch("tuser fill bits", 48'(user[7:5]), '0);
        endtask
    endclass

    arp_table_tracker tracker = new();

    int               idle_cycles = 0;
    int               burst_left  = 0;
    int               stall_mode  = 0;
    logic [7:0]       stall_tick  = '0;
    int               settings    = 0;
    logic [NET_W-1:0] pool[POOL_SIZE];

    arp_cache_lru_top #(
        .ENTRIES(TB_ENTRIES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(negedge clk)
    begin
        stall_tick <= stall_tick + 1'b1;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= (stall_tick % 7) < 4;
            2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= (stall_tick[5:3] != 3'd5);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.match_answer(m_axis_tdata, m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                tracker.take_request(s_axis_tuser[0], s_axis_tdata[15:0],
                                     s_axis_tdata[63:16], s_axis_tdata[79:64],
                                     s_axis_tuser[1]);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timed out after %0d cycles without a beat.", idle_cycles);
                $display("FAIL arp_cache_lru_top");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_item(input logic op, input logic [15:0] peer, input logic [47:0] hw,
                             input logic [15:0] tgt, input logic req);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tgt, hw, peer};
        s_axis_tuser  <= {6'b000000, req, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (tracker.pending_answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_own_addr(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker.own_addr = value;
        settings++;
    endtask

    task automatic random_item();
        int          pick;
        logic [63:0] wide;
        logic [15:0] peer;
        logic [15:0] tgt;
        pick = $urandom_range(0, 99);
        wide = {$urandom(), $urandom()};
        peer = pool[$urandom_range(0, POOL_SIZE - 1)];
        tgt  = ($urandom_range(0, 4) != 0) ? tracker.own_addr : 16'($urandom_range(1, 65535));
        if (pick < 45)
            send_item(OP_LEARN, peer, wide[47:0], tgt, 1'($urandom_range(0, 1)));
        else if (pick < 88)
            send_item(OP_RESOLVE, peer, wide[47:0], wide[63:48], 1'($urandom_range(0, 1)));
        else if (pick < 92)
            send_item(OP_RESOLVE, 16'h0000, wide[47:0], wide[63:48],
                      1'($urandom_range(0, 1)));
        else if (pick < 95)
            send_item(OP_LEARN, ($urandom_range(0, 1) != 0) ? 16'h0000 : peer, wide[47:0],
                      16'h0000, 1'($urandom_range(0, 1)));
        else if (pick < 97)
            send_item(OP_LEARN, 16'h0000, wide[47:0], tgt, 1'($urandom_range(0, 1)));
        else
            send_item(wide[63], wide[15:0], wide[63:16], wide[47:32], wide[0]);
    endtask

    initial
    begin
        logic [15:0] own_values[5];
        own_values = '{16'h0001, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000};
        own_values[2] = 16'($urandom_range(2, 65534));
        own_values[4] = 16'($urandom_range(2, 65534));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Our own address is still zero from reset.
        send_item(OP_RESOLVE, 16'h0000, 48'h0, 16'h0, 1'b0);
        send_item(OP_RESOLVE, 16'h1111, 48'h0, 16'h0, 1'b0);
        send_item(OP_LEARN, 16'h0000, 48'h123456789ABC, 16'h0A01, 1'b1);
        send_item(OP_LEARN, 16'h1111, 48'h123456789ABC, 16'h0000, 1'b1);
        send_item(OP_LEARN, 16'h0000, 48'h0, 16'h0000, 1'b0);
        send_item(OP_LEARN, 16'h1111, 48'h5555_5555_5555, 16'h2222, 1'b1);
        send_item(OP_RESOLVE, 16'h1111, 48'h0, 16'h0, 1'b0);
        drain();
        write_own_addr(16'h0A01);

        send_item(OP_LEARN, 16'h1111, 48'hFFFF_FFFF_FFFF, 16'h0A01, 1'b1);
        send_item(OP_LEARN, 16'hFFFF, 48'h0000_0000_0000, 16'h0A01, 1'b0);
        send_item(OP_RESOLVE, 16'h1111, 48'h0, 16'h0, 1'b0);
        send_item(OP_LEARN, 16'h1111, 48'h0123_4567_89AB, 16'h2222, 1'b1);
        send_item(OP_RESOLVE, 16'h1111, 48'h0, 16'h0, 1'b0);
        send_item(OP_LEARN, 16'hFFFF, 48'hAAAA_AAAA_AAAA, 16'h0A01, 1'b1);
        send_item(OP_RESOLVE, 16'hFFFF, 48'h0, 16'hFFFF, 1'b1);
        send_item(OP_RESOLVE, 16'h0001, 48'h0, 16'h0, 1'b0);
        for (int k = 0; k < 9; k++)
            send_item(OP_LEARN, 16'(16'h0100 + k), {16'hC0DE, 32'(k)}, 16'h0A01, k[0]);

        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            write_own_addr(own_values[ph]);
            stall_mode = ph % 4;
            pool[0] = 16'hFFFF;
            pool[1] = 16'h0001;
            for (int p = 2; p < POOL_SIZE; p++)
                pool[p] = 16'($urandom_range(1, 65535));
            repeat (PHASE_BEATS) random_item();
        end
        drain();
        if (tracker.pending_answers.size() != 0)
            tracker.note_mismatch("results never delivered",
                                  48'(tracker.pending_answers.size()), '0);

        $display("Ran %0d beats over %0d address settings: %0d fills (%0d replacing a peer),",
                 tracker.beats_in, settings, tracker.fills, tracker.evictions);
        $display("%0d learn hits, %0d replies, %0d drops, %0d resolve hits,",
                 tracker.learn_hits, tracker.replies, tracker.drops, tracker.resolve_hits);
        $display("%0d requests and %0d broadcasts.", tracker.requests, tracker.broadcasts);
        if (tracker.errors == 0)
            $display("PASS arp_cache_lru_top");
        else
            $display("FAIL arp_cache_lru_top");
        $finish;
    end

endmodule
